>>> rtl/swpr_pkg.sv
// Shared types and constants for the sliding-window peak-rate counter.
package swpr_pkg;

  localparam int TIME_W = 22;
  localparam int CNT_W  = 11;

  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;

  typedef struct packed {
    logic [4:0] req_day;
    logic [4:0] req_hour;
    logic [5:0] req_minute;
    logic [5:0] req_second;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  window_count;
    logic [CNT_W-1:0]  peak_count;
    logic [TIME_W-1:0] peak_from_time;
    logic [TIME_W-1:0] peak_to_time;
    logic              new_peak;
    logic              fifo_overflow;
  } rsp_t;

endpackage

>>> rtl/swpr_time_mem.sv
// Timestamp memory: one write port, one read port with registered read data.
module swpr_time_mem
  import swpr_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [TIME_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data valid in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/swpr_gap_cmp.sv
// Gap comparator: decides whether the oldest timestamp has left the window.
module swpr_gap_cmp
  import swpr_pkg::*;
(
  input  logic [TIME_W-1:0] old_time,
  input  logic [TIME_W-1:0] new_time,
  input  logic [TIME_W-1:0] window,
  output logic              evict
);

  logic [TIME_W-1:0] gap;

  // Absolute difference of the two wrapped times, then one compare.
  always_comb begin
    if (old_time > new_time) begin
      gap = old_time - new_time;
    end else begin
      gap = new_time - old_time;
    end
    evict = (gap >= window);
  end

endmodule

>>> rtl/sliding_window_peak_rate.sv
// Top level of the sliding-window peak-rate counter.
//
// Each request beat on req carries a time as day, hour, minute and second.
// The block converts it to seconds since the start of day 1, pushes it into
// a timestamp FIFO, evicts entries whose gap to the new time reaches the
// window length, and tracks the peak window count with its start and end
// times. Every request produces exactly one beat on rsp. The window length is
// to be written via cfg_we / cfg_wdata while idle; the user must see to it.
//
// After a request is accepted it passes through S_CONV, S_PUSH, S_LOAD, S_CMP
// and S_DONE; S_CMP repeats once for each entry evicted by that request, and
// the result is registered on leaving S_DONE. req_ready returns in the
// same cycle that the result is loaded, so a new request is taken only once
// the previous result is loaded. In the eviction loop, each evicted entry
// costs one read of the timestamp memory and one pass of the gap comparator.
// A stalled rsp holds its beat; a finished result waits inside the block
// until the output register is free, and req_ready stays low meanwhile.
// Reset clears the FIFO pointers, fill level, peak and the window length
// (to 1); the timestamp memory itself is not cleared.
module sliding_window_peak_rate
  import swpr_pkg::*;
#(
  parameter int FIFO_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(FIFO_DEPTH);
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [LVL_W-1:0]  peak_level;
  logic [TIME_W-1:0] peak_start;
  logic [TIME_W-1:0] peak_end;
  logic [TIME_W-1:0] window;
  logic              raised;
  logic              overflow;
  req_t              req_q;
  logic [TIME_W-1:0] new_time;
  logic [23:0]       sum;
  logic [TIME_W-1:0] conv_time;
  logic [TIME_W-1:0] rd_data;
  logic              evict;
  logic              mem_we;
  logic              full;
  logic              cmp_stop;
  logic              rsp_free;

  assign req_ready = (state == S_IDLE);
  assign full      = (level == LVL_W'(FIFO_DEPTH));
  assign mem_we    = (state == S_PUSH);
  assign cmp_stop  = (level == '0) || !evict;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Time of day conversion, wrapped to the timestamp width.
  always_comb begin
    sum = 24'(req_q.req_day) * 24'(SEC_PER_DAY)
        + 24'(req_q.req_hour) * 24'(SEC_PER_HOUR)
        + 24'(req_q.req_minute) * 24'(SEC_PER_MIN)
        + 24'(req_q.req_second)
        - 24'(SEC_PER_DAY);
    conv_time = sum[TIME_W-1:0];
  end

  swpr_time_mem #(
    .DEPTH(FIFO_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(tail),
    .wr_data(new_time),
    .rd_addr(head_next),
    .rd_data(rd_data)
  );

  swpr_gap_cmp u_gap (
    .old_time(rd_data),
    .new_time(new_time),
    .window  (window),
    .evict   (evict)
  );

  // Sequencer and FIFO pointer updates.
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    level_next = level;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (full) begin
          head_next = (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
        end else begin
          level_next = level + 1'b1;
        end
        tail_next  = (tail == AW'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (cmp_stop) begin
          state_next = S_DONE;
        end else begin
          head_next  = (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
          level_next = level - 1'b1;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      level      <= '0;
      peak_level <= '0;
      peak_start <= '0;
      peak_end   <= '0;
      window     <= TIME_W'(1);
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      level <= level_next;
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (state == S_CMP && cmp_stop && level > peak_level) begin
        peak_level <= level;
        peak_start <= rd_data;
        peak_end   <= new_time;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (state == S_CONV) begin
      new_time <= conv_time;
    end
    if (state == S_PUSH) begin
      overflow <= full;
    end
    if (state == S_CMP && cmp_stop) begin
      raised <= (level > peak_level);
    end
    if (state == S_DONE && rsp_free) begin
      rsp.window_count   <= CNT_W'(level);
      rsp.peak_count     <= CNT_W'(peak_level);
      rsp.peak_from_time <= peak_start;
      rsp.peak_to_time   <= peak_end;
      rsp.new_peak       <= raised;
      rsp.fifo_overflow  <= overflow;
    end
  end

endmodule

>>> rtl/swpr_checker.sv
// Port-level checker for the sliding-window peak-rate counter, with its bind.
module swpr_checker
  import swpr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // One request at a time: ready drops right after a request beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req_ready stayed high after a request beat");

  // A result never appears in the cycle right after a request beat.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result appeared too soon after a request");

  // A raised peak equals the current window count.
  a_new_peak_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.new_peak |-> rsp.peak_count == rsp.window_count)
    else $error("new peak does not match window count");

  // The peak is never below the current window count.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.peak_count >= rsp.window_count)
    else $error("window count exceeds peak count");

  // A stalled result beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

endmodule

bind sliding_window_peak_rate swpr_checker u_swpr_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);
